// ===== src/ufc_pkg.sv =====
// Shared constants and types for the serial frame checker.
package ufc_pkg;

    localparam int BYTE_W = 8;
    localparam int STATUS_W = 2;
    localparam int MAX_FRAME_DEF = 64;
    localparam int MIN_FRAME = 6;

    // Frame marker bytes
    localparam logic [BYTE_W-1:0] HDR_FIRST = 8'hFA;
    localparam logic [BYTE_W-1:0] HDR_SECOND = 8'hAF;
    localparam logic [BYTE_W-1:0] TAIL_FIRST = 8'hA0;
    localparam logic [BYTE_W-1:0] TAIL_SECOND = 8'h0A;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CSUM_ERR = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LEN_ERR = 2'd2;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [STATUS_W-1:0] status_t;

    // One result word as held in the output slots
    typedef struct packed {
        status_t frame_status;
        byte_t led_value;
    } result_t;

endpackage

// ===== src/ufc_rx_if.sv =====
// Handshake channel carrying one received byte per word.
interface ufc_rx_if;
    import ufc_pkg::*;

    logic valid;
    logic ready;
    byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== src/ufc_res_if.sv =====
// Handshake channel carrying one frame check result per word.
interface ufc_res_if;
    import ufc_pkg::*;

    logic valid;
    logic ready;
    status_t frame_status;
    byte_t led_value;

    modport source (output valid, output frame_status, output led_value, input ready);
    modport sink (input valid, input frame_status, input led_value, output ready);
endinterface

// ===== src/uart_frame_checker.sv =====
// Serial frame checker: header hunt, running checksum, length and tail check.
//
// The block takes one received byte per clock while rx.ready is high and hunts for
// the header FA AF; once synced it collects header, length byte, data, checksum and
// tail A0 0A, and on the tail gives one result word: ok with the inverted first data
// byte, checksum error or length error (frames under 6 bytes are length errors). A
// frame that grows past MAX_FRAME bytes is dropped silently and hunting restarts.
// Each byte is folded into the frame state in the cycle it is accepted, so the
// sustained rate is one byte per cycle while rx.ready is high. The result goes into
// the main output register, or into the one skid register when that is full and not
// popped; rx.ready falls only when two results are waiting to be taken.
module uart_frame_checker #(
    parameter int MAX_FRAME = ufc_pkg::MAX_FRAME_DEF
) (
    input logic clk,
    input logic rst_n,
    ufc_rx_if.sink rx,
    ufc_res_if.source res
);
    import ufc_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME + 1);

    // Frame state
    logic synced_reg, synced_next;
    logic [CNT_W-1:0] count_reg, count_next;
    byte_t recent_reg [3];
    byte_t recent_next [3];
    byte_t sum_reg, sum_next;
    byte_t len_reg, len_next;
    byte_t first_reg, first_next;

    // Output slots
    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;

    logic accept;
    logic pop;
    logic produce;
    result_t result;
    logic [CNT_W-1:0] count_inc;
    byte_t length_expect;

    assign accept = rx.valid && rx.ready;
    assign pop = res.valid && res.ready;
    assign rx.ready = !skid_valid_reg;
    assign count_inc = count_reg + CNT_W'(1);
    assign length_expect = BYTE_W'(count_inc) - BYTE_W'(MIN_FRAME);

    // Per-byte frame update
    always_comb
    begin
        synced_next = synced_reg;
        count_next = count_reg;
        recent_next = recent_reg;
        sum_next = sum_reg;
        len_next = len_reg;
        first_next = first_reg;
        produce = 1'b0;
        result.frame_status = ST_OK;
        result.led_value = '0;
        if (accept)
        begin
            if (!synced_reg)
            begin
                if (rx.rx_byte == HDR_SECOND && recent_reg[0] == HDR_FIRST)
                begin
                    synced_next = 1'b1;
                    count_next = CNT_W'(2);
                    recent_next[0] = HDR_SECOND;
                    recent_next[1] = HDR_FIRST;
                    recent_next[2] = '0;
                    sum_next = '0;
                    len_next = '0;
                    first_next = '0;
                end
                else
                begin
                    recent_next[0] = rx.rx_byte;
                end
            end
            else if (count_reg >= CNT_W'(MAX_FRAME))
            begin
                // Overflow: drop the frame, byte counts towards the next header
                synced_next = 1'b0;
                count_next = '0;
                recent_next[0] = rx.rx_byte;
                recent_next[1] = '0;
                recent_next[2] = '0;
                sum_next = '0;
                len_next = '0;
                first_next = '0;
            end
            else
            begin
                if (count_reg >= CNT_W'(3))
                begin
                    sum_next = sum_reg + recent_reg[2];
                end
                recent_next[2] = recent_reg[1];
                recent_next[1] = recent_reg[0];
                recent_next[0] = rx.rx_byte;
                count_next = count_inc;
                if (count_inc == CNT_W'(3))
                begin
                    len_next = rx.rx_byte;
                end
                if (count_inc == CNT_W'(4))
                begin
                    first_next = rx.rx_byte;
                end
                // Tail completes the frame
                if (rx.rx_byte == TAIL_SECOND && recent_reg[0] == TAIL_FIRST)
                begin
                    produce = 1'b1;
                    priority if (count_inc < CNT_W'(MIN_FRAME))
                    begin
                        result.frame_status = ST_LEN_ERR;
                    end
                    else if (sum_next != recent_reg[1])
                    begin
                        result.frame_status = ST_CSUM_ERR;
                    end
                    else if (len_next != length_expect)
                    begin
                        result.frame_status = ST_LEN_ERR;
                    end
                    else
                    begin
                        result.frame_status = ST_OK;
                        result.led_value = ~first_next;
                    end
                    synced_next = 1'b0;
                    count_next = '0;
                    recent_next[0] = '0;
                    recent_next[1] = '0;
                    recent_next[2] = '0;
                    sum_next = '0;
                    len_next = '0;
                    first_next = '0;
                end
            end
        end
    end

    // Output register and skid slot
    always_comb
    begin
        out_valid_next = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next = out_reg;
        skid_next = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_next = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (produce)
        begin
            if (!out_valid_reg || pop)
            begin
                out_next = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next = result;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            synced_reg <= 1'b0;
            count_reg <= '0;
            recent_reg[0] <= '0;
            recent_reg[1] <= '0;
            recent_reg[2] <= '0;
            sum_reg <= '0;
            len_reg <= '0;
            first_reg <= '0;
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            synced_reg <= synced_next;
            count_reg <= count_next;
            recent_reg <= recent_next;
            sum_reg <= sum_next;
            len_reg <= len_next;
            first_reg <= first_next;
            out_valid_reg <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        skid_reg <= skid_next;
    end

    assign res.valid = out_valid_reg;
    assign res.frame_status = out_reg.frame_status;
    assign res.led_value = out_reg.led_value;

    // Skid slot is only used behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot full with output register empty");

    // While hunting the byte count stays clear
    a_hunt_count: assert property (@(posedge clk) disable iff (!rst_n)
        !synced_reg |-> count_reg == '0)
        else $error("byte count nonzero while hunting");

    // A synced frame holds between two and MAX_FRAME bytes
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        synced_reg |-> (count_reg >= CNT_W'(2) && count_reg <= CNT_W'(MAX_FRAME)))
        else $error("byte count out of range while synced");

    // Error results carry a zero LED value
    a_led_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.frame_status != ST_OK) |-> out_reg.led_value == '0)
        else $error("LED value set on an error result");

    // A tail accepted with room produces a result on the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (produce && !out_valid_reg) |=> out_valid_reg)
        else $error("result lost after frame tail");

endmodule
